[rtl/core/pifb_pkg.sv]
// ----------------------------------------------------------------------------
// pifb_pkg
// Shared widths, register indexes and defaults of the price indicator bank.
// ----------------------------------------------------------------------------
package pifb_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  localparam int PRICE_W   = 32;
  localparam int AVG_W     = 32;
  localparam int SLOPE_W   = 34;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CFG   = 7;
  localparam int NUM_AVG   = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUY_FAST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUY_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUY_SLOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SELL_FAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SELL_MID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SELL_SLOW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd6;

  localparam logic [CFG_W-1:0] FAST_RST  = 7'd1;
  localparam logic [CFG_W-1:0] MID_RST   = 7'd2;
  localparam logic [CFG_W-1:0] SLOW_RST  = 7'd3;
  localparam logic [CFG_W-1:0] SLOPE_RST = 7'd4;

endpackage

[rtl/core/pifb_if.sv]
// ----------------------------------------------------------------------------
// pifb_if
// Valid/ready channels of the price indicator bank: samples, results, config.
// ----------------------------------------------------------------------------
interface pifb_price_if;
  logic                         valid;
  logic                         ready;
  logic [pifb_pkg::PRICE_W-1:0] price;
  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface pifb_result_if;
  logic                               valid;
  logic                               ready;
  logic [pifb_pkg::AVG_W-1:0]         buy_fast_avg;
  logic [pifb_pkg::AVG_W-1:0]         buy_mid_avg;
  logic [pifb_pkg::AVG_W-1:0]         buy_slow_avg;
  logic [pifb_pkg::AVG_W-1:0]         sell_fast_avg;
  logic [pifb_pkg::AVG_W-1:0]         sell_mid_avg;
  logic [pifb_pkg::AVG_W-1:0]         sell_slow_avg;
  logic signed [pifb_pkg::SLOPE_W-1:0] trend_slope;
  logic                               ready_res;
  modport source (output valid, output buy_fast_avg, output buy_mid_avg,
                  output buy_slow_avg, output sell_fast_avg, output sell_mid_avg,
                  output sell_slow_avg, output trend_slope, output ready_res,
                  input ready);
  modport sink   (input valid, input buy_fast_avg, input buy_mid_avg,
                  input buy_slow_avg, input sell_fast_avg, input sell_mid_avg,
                  input sell_slow_avg, input trend_slope, input ready_res,
                  output ready);
endinterface

interface pifb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pifb_pkg::CFG_IDX_W-1:0] reg_index;
  logic [pifb_pkg::CFG_W-1:0]     data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

[rtl/core/price_indicator_filter_bank_top.sv]
// ----------------------------------------------------------------------------
// price_indicator_filter_bank_top
// Six moving averages and a least-squares slope over a ring of price samples.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one price item (unsigned Q16.16) per handshake. ready is high
//             only while the block is idle.
//   results : one item per sample: six averages, the slope and ready_res.
//   cfg     : register writes (index, data), always ready; write only while idle.
// Steps per item: accept, then read the history memory over W entries
//   (W = largest effective window), drain the read pipeline, start the
//   dividers and wait for all seven, running side by side, to finish, then
//   load the result register. The block takes no new sample until it is
//   back in idle, after the result register is loaded. The memory read port
//   and the bit-serial dividers set the time per item. During warm-up the
//   scan and divide steps are skipped and the result is zero.
// Reset clears the write pointer, the sample count and the registers to
// their defaults; the history memory is not cleared, as no window reaches
// an entry before it was written.
// A stalled receiver holds the result register; the next sample is still
// accepted and processed, and waits for the register before it is loaded.
// ----------------------------------------------------------------------------
module price_indicator_filter_bank_top #(
  parameter int MAX_WINDOW = pifb_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = pifb_pkg::PRICE_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  pifb_price_if.sink    samples,
  pifb_result_if.source results,
  pifb_cfg_if.sink      cfg
);

  import pifb_pkg::*;

  localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W    = $clog2(MAX_WINDOW);
  localparam int SAMPLE_W = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int SUM_W    = SAMPLE_W + LEN_W;
  localparam int COEF_W   = LEN_W + 2;
  localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
  localparam int ACC_S_W  = SAMPLE_W + 2 * LEN_W + 1;
  localparam int DIV_W    = ACC_S_W + 2;
  localparam int DEN_W    = 3 * LEN_W;
  localparam int QX_W     = (DIV_W > SLOPE_W) ? DIV_W : SLOPE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_START, S_DIV, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_W-1:0] cfg_reg [NUM_CFG];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg[CFG_BUY_FAST]  <= FAST_RST;
      cfg_reg[CFG_BUY_MID]   <= MID_RST;
      cfg_reg[CFG_BUY_SLOW]  <= SLOW_RST;
      cfg_reg[CFG_SELL_FAST] <= FAST_RST;
      cfg_reg[CFG_SELL_MID]  <= MID_RST;
      cfg_reg[CFG_SELL_SLOW] <= SLOW_RST;
      cfg_reg[CFG_SLOPE]     <= SLOPE_RST;
    end else if (cfg.valid && (cfg.reg_index < CFG_IDX_W'(NUM_CFG))) begin
      cfg_reg[cfg.reg_index] <= cfg.data;
    end
  end

  // clamp a raw window length into lo..MAX_WINDOW
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] raw, input int lo);
    logic [LEN_W-1:0] res;
    if (int'(raw) < lo) begin
      res = LEN_W'(lo);
    end else if (int'(raw) > MAX_WINDOW) begin
      res = LEN_W'(MAX_WINDOW);
    end else begin
      res = LEN_W'(raw);
    end
    return res;
  endfunction

  logic [LEN_W-1:0] len [NUM_CFG];
  logic [LEN_W-1:0] maxw;

  always_comb begin
    maxw = '0;
    for (int j = 0; j < NUM_CFG; j++) begin
      len[j] = eff_len(cfg_reg[j], (j == int'(CFG_SLOPE)) ? 2 : 1);
      if (len[j] > maxw) begin
        maxw = len[j];
      end
    end
  end

  // slope denominator n*(n*n-1), one multiply per register
  logic [2*LEN_W-1:0] nsq_m1;
  logic [DEN_W-1:0]   den;

  always_ff @(posedge clk) begin
    nsq_m1 <= (2*LEN_W)'(len[CFG_SLOPE]) * (2*LEN_W)'(len[CFG_SLOPE]) - (2*LEN_W)'(1);
    den    <= DEN_W'(len[CFG_SLOPE]) * DEN_W'(nsq_m1);
  end

  // write pointer, sample count, scan control
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] newest;
  logic [LEN_W-1:0] seen;
  logic [LEN_W-1:0] k;
  logic             warm;
  logic             accept;
  logic             scan_rd;
  logic [PTR_W-1:0] raddr;

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign scan_rd       = (state == S_SCAN);

  // newest minus k, modulo the ring depth
  always_comb begin
    if (LEN_W'(newest) >= k) begin
      raddr = PTR_W'(LEN_W'(newest) - k);
    end else begin
      raddr = PTR_W'(LEN_W'(newest) + LEN_W'(MAX_WINDOW) - k);
    end
  end

  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_valid;

  // the sample is written at the accept edge, before the first read of the scan
  pifb_ring #(.DEPTH(MAX_WINDOW), .W(SAMPLE_W)) u_ring (
    .clk    (clk),
    .rst    (rst),
    .we     (accept),
    .waddr  (wp),
    .wdata  (samples.price[SAMPLE_W-1:0]),
    .re     (scan_rd),
    .raddr  (raddr),
    .rdata  (rd_data),
    .rvalid (rd_valid)
  );

  // read pipeline: k follows the memory read, then product, then accumulate
  logic [LEN_W-1:0]          k1;
  logic [LEN_W-1:0]          k2;
  logic                      v2;
  logic [SAMPLE_W-1:0]       y2;
  logic signed [COEF_W-1:0]  coef;
  logic signed [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]          sma_acc [NUM_AVG];
  logic signed [ACC_S_W-1:0] slope_acc;

  // coefficient (n-1) - 2k for the k-th newest sample, zero outside the fit
  always_comb begin
    if (k1 < len[CFG_SLOPE]) begin
      coef = $signed({2'b00, len[CFG_SLOPE]}) - COEF_W'(1) - $signed({1'b0, k1, 1'b0});
    end else begin
      coef = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_rd) begin
      k1 <= k;
    end
    k2   <= k1;
    y2   <= rd_data;
    prod <= coef * $signed({1'b0, rd_data});
    if (accept) begin
      for (int j = 0; j < NUM_AVG; j++) begin
        sma_acc[j] <= '0;
      end
      slope_acc <= '0;
    end else if (v2) begin
      for (int j = 0; j < NUM_AVG; j++) begin
        if (k2 < len[j]) begin
          sma_acc[j] <= sma_acc[j] + SUM_W'(y2);
        end
      end
      slope_acc <= slope_acc + ACC_S_W'(prod);
    end
  end

  // dividers
  logic                     div_start;
  logic [NUM_AVG:0]         div_busy;
  logic [SUM_W-1:0]         avg_q [NUM_AVG];
  logic [DIV_W-1:0]         slope_q;
  logic                     slope_neg;
  logic [ACC_S_W-1:0]       slope_mag;
  logic [DIV_W-1:0]         slope_num;

  assign div_start = (state == S_START);
  assign slope_neg = slope_acc < 0;
  assign slope_mag = slope_neg ? ACC_S_W'(-slope_acc) : ACC_S_W'(slope_acc);
  assign slope_num = (DIV_W'(slope_mag) << 2) + (DIV_W'(slope_mag) << 1);

  for (genvar g = 0; g < NUM_AVG; g++) begin : g_avg
    pifb_div #(.N_W(SUM_W), .D_W(LEN_W)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (sma_acc[g]),
      .divisor  (len[g]),
      .busy     (div_busy[g]),
      .quotient (avg_q[g])
    );
  end

  pifb_div #(.N_W(DIV_W), .D_W(DEN_W)) u_slope_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (slope_num),
    .divisor  (den),
    .busy     (div_busy[NUM_AVG]),
    .quotient (slope_q)
  );

  logic [QX_W-1:0] slope_x;
  logic            neg_hold;

  assign slope_x = neg_hold ? QX_W'(-QX_W'(slope_q)) : QX_W'(slope_q);

  // result register
  logic                      res_valid;
  logic [AVG_W-1:0]          res_avg [NUM_AVG];
  logic signed [SLOPE_W-1:0] res_slope;
  logic                      res_ok;

  assign results.valid         = res_valid;
  assign results.buy_fast_avg  = res_avg[0];
  assign results.buy_mid_avg   = res_avg[1];
  assign results.buy_slow_avg  = res_avg[2];
  assign results.sell_fast_avg = res_avg[3];
  assign results.sell_mid_avg  = res_avg[4];
  assign results.sell_slow_avg = res_avg[5];
  assign results.trend_slope   = res_slope;
  assign results.ready_res     = res_ok;

  logic out_free;
  assign out_free = !res_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      newest    <= '0;
      seen      <= '0;
      k         <= '0;
      warm      <= 1'b0;
      neg_hold  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // load a new result, or drop the one the receiver just took
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            // store the sample, advance the pointer, count the history
            newest <= wp;
            wp     <= (wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;
            if (seen < LEN_W'(MAX_WINDOW)) begin
              seen <= seen + 1'b1;
            end
            warm  <= seen < maxw;
            k     <= '0;
            state <= (seen < maxw) ? S_OUT : S_SCAN;
          end
        end
        S_SCAN: begin
          k <= k + 1'b1;
          if (k == maxw - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait for the last read to reach the accumulators
          if (!rd_valid && !v2) begin
            state <= S_START;
          end
        end
        S_START: begin
          neg_hold <= slope_neg;
          state    <= S_DIV;
        end
        S_DIV: begin
          if (div_busy == '0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      for (int j = 0; j < NUM_AVG; j++) begin
        res_avg[j] <= warm ? '0 : AVG_W'(avg_q[j]);
      end
      res_slope <= warm ? '0 : slope_x[SLOPE_W-1:0];
      res_ok    <= !warm;
    end
  end

endmodule

[rtl/core/pifb_ring.sv]
// ----------------------------------------------------------------------------
// pifb_ring
// Sample history memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pifb_ring #(
  parameter int DEPTH = 64,
  parameter int W     = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata,
  output logic                     rvalid
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= re;
    end
  end

endmodule

[rtl/core/pifb_div.sv]
// ----------------------------------------------------------------------------
// pifb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pifb_div #(
  parameter int N_W = 38,
  parameter int D_W = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [CNT_W-1:0] count;
  logic [D_W:0]     trial;
  logic             take;

  assign trial = {rem, quotient[N_W-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(N_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? D_W'(trial - {1'b0, dvs}) : trial[D_W-1:0];
      quotient <= {quotient[N_W-2:0], take};
    end
  end

endmodule
